// ===== rtl/ism_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ism_pkg
// Shared types and constants of the integer stack machine: opcodes, status
// codes, request and response payloads and the control word of a stack cell.
// ----------------------------------------------------------------------------
package ism_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W      = 32;

   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_PALL = 3'd1,
      OP_POP  = 3'd2,
      OP_PINT = 3'd3,
      OP_SUB  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_POP_EMPTY  = 3'd1,
      ST_PINT_EMPTY = 3'd2,
      ST_SUB_SHORT  = 3'd3,
      ST_FULL       = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]               op;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic                     has_data;
      logic [2:0]               status;
      logic                     last;
   } rsp_type;

   // what every cell does in a cycle
   typedef enum logic [2:0] {
      CM_HOLD   = 3'd0,
      CM_DOWN   = 3'd1,
      CM_UP     = 3'd2,
      CM_ROTATE = 3'd3,
      CM_SUB    = 3'd4
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type mode;
      logic          is_head;
      logic          is_last;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ===== rtl/ism_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ism_cell
// One stack entry. Takes its neighbour's word on push, pop and subtract, and
// joins a rotation of the occupied entries while the stack is printed.
// ----------------------------------------------------------------------------
module ism_cell
   import ism_pkg::*;
(
   input  wire                            clock,
   input  wire cell_ctrl_type             ctrl,
   input  wire logic signed [DATA_W-1:0]  up_data,
   input  wire logic signed [DATA_W-1:0]  down_data,
   input  wire logic signed [DATA_W-1:0]  top_data,
   output logic signed [DATA_W-1:0]       cell_data
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      unique case (ctrl.mode)
         CM_DOWN:   data_in = up_data;
         CM_UP:     data_in = down_data;
         // the last occupied entry picks up the old top to close the ring
         CM_ROTATE: data_in = ctrl.is_last ? top_data : down_data;
         CM_SUB:    data_in = ctrl.is_head ? (down_data - data_ff) : down_data;
         default:   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_data = data_ff;

endmodule
`default_nettype wire

// ===== rtl/integer_stack_machine.sv =====
`default_nettype none
// A request's first response is in the output register the cycle after it is taken.
// Throughput: one request per cycle for push, pop, print-top and subtract while
// the output is not stalled. Print-all of n entries streams n responses, one per
// unstalled cycle, by rotating the cell chain; new requests wait until it is done.
// Reset clears the entry count and control; entry contents are left as they are.
// ----------------------------------------------------------------------------
// integer_stack_machine
// Bounded stack of signed 32-bit integers held in a chain of cells, top in
// the first cell. Push shifts the chain down, pop and subtract shift it up.
// ----------------------------------------------------------------------------
module integer_stack_machine
   import ism_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output rsp_type      rsp_payload
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_PALL = 2'b10
   } state_type;

   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [COUNT_W-1:0]     remain_ff, remain_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;
   cell_mode_type          mode;
   cell_ctrl_type          ctrl [STACK_DEPTH];
   logic signed [DATA_W-1:0] cells [STACK_DEPTH];
   logic                   out_free;
   logic                   accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mode         = CM_HOLD;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in    = 1'b1;
               rsp_in.data     = '0;
               rsp_in.has_data = 1'b0;
               rsp_in.status   = ST_OK;
               rsp_in.last     = 1'b1;
               unique case (req_payload.op)
                  OP_PUSH: begin
                     if (count_ff == COUNT_W'(STACK_DEPTH)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        mode     = CM_DOWN;
                        count_in = count_ff + COUNT_W'(1);
                     end
                  end
                  OP_PALL: begin
                     if (count_ff != '0) begin
                        rsp_in.data     = cells[0];
                        rsp_in.has_data = 1'b1;
                        rsp_in.last     = (count_ff == COUNT_W'(1));
                        mode            = CM_ROTATE;
                        if (count_ff != COUNT_W'(1)) begin
                           state_in  = S_PALL;
                           remain_in = count_ff - COUNT_W'(1);
                        end
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_POP_EMPTY;
                     end else begin
                        mode     = CM_UP;
                        count_in = count_ff - COUNT_W'(1);
                     end
                  end
                  OP_PINT: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_PINT_EMPTY;
                     end else begin
                        rsp_in.data     = cells[0];
                        rsp_in.has_data = 1'b1;
                     end
                  end
                  OP_SUB: begin
                     if (count_ff < COUNT_W'(2)) begin
                        rsp_in.status = ST_SUB_SHORT;
                     end else begin
                        mode     = CM_SUB;
                        count_in = count_ff - COUNT_W'(1);
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_PALL: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.data     = cells[0];
               rsp_in.has_data = 1'b1;
               rsp_in.status   = ST_OK;
               rsp_in.last     = (remain_ff == COUNT_W'(1));
               mode            = CM_ROTATE;
               remain_in       = remain_ff - COUNT_W'(1);
               if (remain_ff == COUNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         ctrl[i].mode    = mode;
         ctrl[i].is_head = (i == 0);
         ctrl[i].is_last = (count_ff == COUNT_W'(i + 1));
      end
   end

   genvar g;
   generate
      for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
         logic signed [DATA_W-1:0] up_d;
         logic signed [DATA_W-1:0] down_d;
         if (g == 0) begin : g_head
            assign up_d = req_payload.value;
         end else begin : g_body
            assign up_d = cells[g-1];
         end
         if (g == STACK_DEPTH - 1) begin : g_tail
            assign down_d = '0;
         end else begin : g_inner
            assign down_d = cells[g+1];
         end
         ism_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl[g]),
            .up_data   (up_d),
            .down_data (down_d),
            .top_data  (cells[0]),
            .cell_data (cells[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// ===== verif/tb_integer_stack_machine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_stack_machine
// Self-checking bench for the integer stack machine. A queue of requests
// (directed corner cases, a fill-to-full and drain sequence, then random
// episodes that grow and shrink the stack) feeds a clocked driver. Each
// accepted request updates a local copy of the stack and queues the responses
// it should give. A clocked monitor compares every accepted response with the
// oldest expected one, field by field, under random stalls.
// ----------------------------------------------------------------------------
module tb_integer_stack_machine;
   import ism_pkg::*;

   // opcodes the block does not define; they must behave as a no-op
   localparam logic [2:0] OP_SPARE5 = 3'd5;
   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;

   localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

   localparam int RANDOM_REQS = 360;
   localparam int DRAIN_CYCLES = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // local copy of the stack, entry 0 is the bottom
   logic signed [DATA_W-1:0] stack_copy [STACK_DEPTH];
   int                       stack_fill = 0;

   req_type pending_req [$];
   rsp_type expected_rsp [$];

   int queued_count   = 0;
   int accepted_count = 0;
   int rsp_seen       = 0;
   int fail_count     = 0;

   int send_wait = 0;
   int send_calm = 0;
   int stall_left = 0;
   int open_left  = 0;
   int hold_left  = 0;
   bit hold_done  = 1'b0;

   integer_stack_machine u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 45);
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_value();
      case ($urandom_range(0, 19))
         0:       return INT_MIN;
         1:       return INT_MAX;
         2:       return '0;
         3:       return -1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_op(int push_pct);
      int r;
      if ($urandom_range(0, 99) < push_pct) return OP_PUSH;
      r = $urandom_range(0, 99);
      if (r < 5) return OP_PALL;
      if (r < 30) return OP_POP;
      if (r < 55) return OP_PINT;
      if (r < 95) return OP_SUB;
      case ($urandom_range(0, 2))
         0:       return OP_SPARE5;
         1:       return OP_SPARE6;
         default: return OP_SPARE7;
      endcase
   endfunction

   task automatic queue_req(input logic [2:0] op, input logic signed [DATA_W-1:0] value);
      req_type r;
      r.op    = op;
      r.value = value;
      pending_req.push_back(r);
      queued_count++;
   endtask

   task automatic add_expected(input logic signed [DATA_W-1:0] data, input logic has_data,
                               input logic [2:0] status, input logic last);
      rsp_type r;
      r.data     = data;
      r.has_data = has_data;
      r.status   = status;
      r.last     = last;
      expected_rsp.push_back(r);
   endtask

   // updates the stack copy and queues the responses of one request
   task automatic apply_stack_op(input req_type r);
      int i;
      case (r.op)
         OP_PUSH: begin
            if (stack_fill >= STACK_DEPTH) begin
               add_expected('0, 1'b0, ST_FULL, 1'b1);
            end else begin
               stack_copy[stack_fill] = r.value;
               stack_fill++;
               add_expected('0, 1'b0, ST_OK, 1'b1);
            end
         end
         OP_PALL: begin
            if (stack_fill == 0) begin
               add_expected('0, 1'b0, ST_OK, 1'b1);
            end else begin
               for (i = stack_fill - 1; i >= 0; i--)
                  add_expected(stack_copy[i], 1'b1, ST_OK, i == 0);
            end
         end
         OP_POP: begin
            if (stack_fill == 0) begin
               add_expected('0, 1'b0, ST_POP_EMPTY, 1'b1);
            end else begin
               stack_fill--;
               add_expected('0, 1'b0, ST_OK, 1'b1);
            end
         end
         OP_PINT: begin
            if (stack_fill == 0) add_expected('0, 1'b0, ST_PINT_EMPTY, 1'b1);
            else add_expected(stack_copy[stack_fill-1], 1'b1, ST_OK, 1'b1);
         end
         OP_SUB: begin
            if (stack_fill < 2) begin
               add_expected('0, 1'b0, ST_SUB_SHORT, 1'b1);
            end else begin
               // second minus top, wrapping at 32 bits
               stack_copy[stack_fill-2] = stack_copy[stack_fill-2] - stack_copy[stack_fill-1];
               stack_fill--;
               add_expected('0, 1'b0, ST_OK, 1'b1);
            end
         end
         default: add_expected('0, 1'b0, ST_OK, 1'b1);
      endcase
   endtask

   task automatic report_field(input string name, input longint want, input longint got);
      fail_count++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
   endtask

   task automatic check_response(input rsp_type got);
      rsp_type want;
      if (expected_rsp.size() == 0) begin
         fail_count++;
         $error("response with none expected: data %0d status %0d", got.data, got.status);
      end else begin
         want = expected_rsp.pop_front();
         if (got.data !== want.data) report_field("data", want.data, got.data);
         if (got.has_data !== want.has_data)
            report_field("has_data", want.has_data, got.has_data);
         if (got.status !== want.status) report_field("status", want.status, got.status);
         if (got.last !== want.last) report_field("last", want.last, got.last);
      end
   endtask

   task automatic wait_idle();
      while (accepted_count != queued_count || expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_stack_op(req_payload);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (pending_req.size() > 0) begin
               req_valid   <= 1'b1;
               req_payload <= pending_req.pop_front();
               if (send_calm > 0) begin
                  send_calm--;
                  send_wait = 0;
               end else begin
                  send_wait = idle_len();
                  if ($urandom_range(0, 49) == 0) send_calm = 40;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_response(rsp_payload);
            rsp_seen++;
         end
         // one long hold-off while plenty of requests are still waiting
         if (!hold_done && rsp_seen > 30 && pending_req.size() > 20) begin
            hold_done = 1'b1;
            hold_left = 120;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (open_left > 0) begin
            open_left--;
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 24) == 0) begin
               open_left  = 60;
               stall_left = 0;
            end else begin
               open_left  = $urandom_range(0, 8);
               stall_left = idle_len();
            end
         end
      end
   end

   initial begin
      int i;
      int n;
      int push_pct;
      int target;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // corner cases on an empty and nearly empty stack
      queue_req(OP_POP, rand_value());
      queue_req(OP_PINT, rand_value());
      queue_req(OP_SUB, rand_value());
      queue_req(OP_PALL, rand_value());
      queue_req(OP_PUSH, 1);
      queue_req(OP_SUB, rand_value());
      queue_req(OP_SPARE5, INT_MAX);
      queue_req(OP_SPARE6, INT_MIN);
      queue_req(OP_SPARE7, -1);
      // min minus one wraps round to max
      queue_req(OP_PUSH, INT_MIN);
      queue_req(OP_PUSH, 1);
      queue_req(OP_SUB, '0);
      queue_req(OP_PINT, '0);
      queue_req(OP_PUSH, -1);
      queue_req(OP_PUSH, INT_MAX);
      queue_req(OP_PUSH, '0);
      queue_req(OP_PALL, '0);
      queue_req(OP_SUB, '0);
      queue_req(OP_SUB, '0);
      queue_req(OP_PALL, '0);
      queue_req(OP_POP, '0);
      queue_req(OP_POP, '0);
      queue_req(OP_POP, '0);
      queue_req(OP_PALL, '0);
      wait_idle();

      target = queued_count + RANDOM_REQS;

      // fill past full, dump everything, then drain
      for (i = 0; i < STACK_DEPTH + 2; i++) queue_req(OP_PUSH, rand_value());
      queue_req(OP_PALL, rand_value());
      queue_req(OP_PINT, rand_value());
      for (i = 0; i < 70; i++) queue_req(pick_op(10), rand_value());
      wait_idle();

      // episodes that grow, shrink or churn the stack
      while (queued_count < target) begin
         case ($urandom_range(0, 2))
            0:       push_pct = 70;
            1:       push_pct = 20;
            default: push_pct = 45;
         endcase
         n = $urandom_range(8, 30);
         for (i = 0; i < n; i++) queue_req(pick_op(push_pct), rand_value());
         if ($urandom_range(0, 3) == 0) wait_idle();
      end
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
